### rtl/itrd_pkg.sv
// shared types, constants and helpers for the radix digit converter
package itrd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;
    localparam int PTR_W       = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W       = $clog2(VALUE_WIDTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] RADIX_MIN       = 6'd2;
    localparam logic [5:0] RADIX_MAX       = 6'd36;
    localparam logic [5:0] DIGIT_MAX       = 6'd9;
    localparam logic [6:0] CHAR_ZERO       = 7'd48;  // '0'
    localparam logic [6:0] CHAR_ALPHA_BASE = 7'd55;  // 'A' - 10

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  radix;
        logic [5:0]  min_digits;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
        logic       error;
    } t_out_beat;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [5:0]             radix;
        logic [CNT_W-1:0]       min_count;
        logic                   bad;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PAD,
        ST_READ,
        ST_EMIT
    } t_back_state;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] base;
        base = (d > DIGIT_MAX) ? CHAR_ALPHA_BASE : CHAR_ZERO;
        return base + 7'(d);
    endfunction

endpackage

### rtl/itrd_front.sv
// input stage: takes beats, checks the radix and clamps the minimum digit count
module itrd_front
    import itrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_data,
    output logic     o_job_valid,
    input  logic     i_job_ready,
    output t_job     o_job
);

    logic r_valid;
    t_job r_job;
    t_job job_cls;
    logic accept;

    always_comb begin
        job_cls.value = VALUE_WIDTH'(i_data.value);
        job_cls.radix = i_data.radix;
        job_cls.bad   = !(i_data.radix inside {[RADIX_MIN:RADIX_MAX]});
        if (i_data.min_digits == 6'd0) begin
            job_cls.min_count = CNT_W'(1);
        end else if (int'(i_data.min_digits) > MAX_DIGITS) begin
            job_cls.min_count = CNT_W'(MAX_DIGITS);
        end else begin
            job_cls.min_count = CNT_W'(i_data.min_digits);
        end
    end

    assign o_ready     = !r_valid || i_job_ready;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= job_cls;
        end
    end

endmodule

### rtl/itrd_queue.sv
// short job queue between the input stage and the conversion engine
module itrd_queue
    import itrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = int'(r_count) < QUEUE_DEPTH;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### rtl/itrd_back.sv
// conversion engine: bit-serial divider, digit store, zero fill and character output
module itrd_back
    import itrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    t_back_state            r_state;
    t_back_state            n_state;

    logic [5:0]             r_store [MAX_DIGITS];
    logic [5:0]             r_rd_data;

    logic [VALUE_WIDTH-1:0] r_q;
    logic [5:0]             r_rem;
    logic [BIT_W-1:0]       r_bit;
    logic [5:0]             r_radix;
    logic [CNT_W-1:0]       r_min;
    logic [CNT_W-1:0]       r_count;
    logic [PTR_W-1:0]       r_wptr;
    logic                   r_ovf;
    logic [PTR_W-1:0]       r_idx;
    logic                   r_err;
    logic                   r_out_valid;
    t_out_beat              r_out;

    // divider step
    logic [5:0]             rem_in;
    logic [6:0]             rem_sh;
    logic                   rem_ge;
    logic [5:0]             rem_new;
    logic [VALUE_WIDTH-1:0] q_new;
    logic                   digit_done;
    logic                   q_zero;

    logic                   wr_en;
    logic [PTR_W-1:0]       wr_addr;
    logic [5:0]             wr_data;
    logic [PTR_W:0]         rd_sum;
    logic [PTR_W-1:0]       rd_addr;
    logic                   out_load;
    logic                   pad_more;
    logic [PTR_W-1:0]       wptr_inc;

    always_comb begin
        rem_in     = (r_bit == '0) ? 6'd0 : r_rem;
        rem_sh     = {rem_in, r_q[VALUE_WIDTH-1]};
        rem_ge     = rem_sh >= {1'b0, r_radix};
        rem_new    = rem_ge ? 6'(rem_sh - {1'b0, r_radix}) : rem_sh[5:0];
        q_new      = {r_q[VALUE_WIDTH-2:0], rem_ge};
        digit_done = int'(r_bit) == VALUE_WIDTH - 1;
        q_zero     = r_q == '0;
        pad_more   = r_count < r_min;
        wptr_inc   = (int'(r_wptr) == MAX_DIGITS - 1) ? '0 : r_wptr + PTR_W'(1);
    end

    // most significant kept digit sits just below the write pointer after wrap
    always_comb begin
        rd_sum = (r_ovf ? {1'b0, r_wptr} : '0) + {1'b0, r_idx};
        if (int'(rd_sum) >= MAX_DIGITS) begin
            rd_addr = PTR_W'(rd_sum - (PTR_W + 1)'(MAX_DIGITS));
        end else begin
            rd_addr = rd_sum[PTR_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.bad ? ST_EMIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (r_bit == '0 && q_zero) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (!pad_more) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = (r_err || r_idx == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_job_ready = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_wptr;
        wr_data     = rem_new;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
            end
            ST_DIVIDE: begin
                wr_en = digit_done;
            end
            ST_PAD: begin
                wr_en   = pad_more;
                wr_addr = r_count[PTR_W-1:0];
                wr_data = 6'd0;
            end
            ST_EMIT: begin
                out_load = !r_out_valid || i_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_err   <= i_job.bad;
                    r_q     <= i_job.value;
                    r_radix <= i_job.radix;
                    r_min   <= i_job.min_count;
                    r_count <= '0;
                    r_wptr  <= '0;
                    r_ovf   <= 1'b0;
                    r_bit   <= '0;
                end
            end
            ST_DIVIDE: begin
                if (!(r_bit == '0 && q_zero)) begin
                    r_q   <= q_new;
                    r_rem <= rem_new;
                    if (digit_done) begin
                        r_bit  <= '0;
                        r_wptr <= wptr_inc;
                        if (int'(r_count) < MAX_DIGITS) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else begin
                        r_bit <= r_bit + BIT_W'(1);
                    end
                end
            end
            ST_PAD: begin
                if (pad_more) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_idx <= PTR_W'(r_count - CNT_W'(1));
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (r_err) begin
                        r_out.char_code <= 7'd0;
                        r_out.last      <= 1'b1;
                        r_out.error     <= 1'b1;
                    end else begin
                        r_out.char_code <= digit_char(r_rd_data);
                        r_out.last      <= r_idx == '0;
                        r_out.error     <= 1'b0;
                        r_idx           <= r_idx - PTR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### rtl/integer_to_radix_digits.sv
// top level of the radix digit converter
//
// input channel (i_valid / o_ready, i_data): one beat per number, carrying the
// value, the radix and the minimum digit count. output channel (o_valid /
// i_ready, o_data): one beat per ASCII digit, most significant first, with
// last set on the final digit. a radix outside 2..36 gives a single beat with
// char_code 0, last and error set.
// an input stage classifies each number and a two-entry job queue feeds the
// conversion engine, so new numbers are taken while the engine is busy.
// the engine holds one number at a time. each digit comes from a restoring
// bit-serial divider that takes one quotient bit per cycle, zero fill
// writes zero digits up to the minimum count, and each character is read
// from the registered digit store in ST_READ and loaded into the output
// register in ST_EMIT.
// a stalled receiver holds the output register and the engine waits on it.
// synchronous active-low reset empties the queue and idles the engine; the
// digit store needs no clearing.
module integer_to_radix_digits
    import itrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic queue_valid;
    logic queue_ready;
    t_job queue_job;

    itrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    itrd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_job)
    );

    itrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_ready (queue_ready),
        .i_job       (queue_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for integer_to_radix_digits: directed and random numbers checked against a local converter
module tb_top
    import itrd_pkg::*;
();

    localparam int LONG_HOLD  = 1500;  // receiver hold-off used to fill the block
    localparam int TAIL_WAIT  = 64;    // quiet cycles after the last expected char
    localparam int RANDOM_NUM = 380;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      tx_valid = 1'b0;
    t_in_beat  tx_data = '0;
    logic      rx_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_beat o_data;

    t_out_beat pending_chars[$];
    int        mismatches = 0;

    // receiver state
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mode_left = 0;
    int stall_pct = 0;

    integer_to_radix_digits dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tx_valid),
        .o_ready (o_ready),
        .i_data  (tx_data),
        .o_valid (o_valid),
        .i_ready (rx_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #25_000_000;
        $display("integer_to_radix_digits: mismatch");
        $finish;
    end

    function automatic logic [6:0] digit_ascii(input logic [5:0] d);
        return (d > DIGIT_MAX) ? CHAR_ALPHA_BASE + 7'(d) : CHAR_ZERO + 7'(d);
    endfunction

    // works out the chars one number turns into, most significant first
    function automatic void convert_number(input t_in_beat num);
        logic [5:0]  digits [MAX_DIGITS];
        logic [31:0] rest;
        int unsigned count;
        int unsigned fill_to;
        t_out_beat   ch;
        if (num.radix < RADIX_MIN || num.radix > RADIX_MAX) begin
            ch.char_code = '0;
            ch.last      = 1'b1;
            ch.error     = 1'b1;
            pending_chars.push_back(ch);
            return;
        end
        rest  = num.value;
        count = 0;
        while (rest != 0) begin
            digits[count] = 6'(rest % 32'(num.radix));
            count++;
            rest = rest / 32'(num.radix);
        end
        fill_to = (num.min_digits == 0) ? 1 : num.min_digits;
        if (fill_to > MAX_DIGITS) fill_to = MAX_DIGITS;
        while (count < fill_to) begin
            digits[count] = '0;
            count++;
        end
        for (int i = count - 1; i >= 0; i--) begin
            ch.char_code = digit_ascii(digits[i]);
            ch.last      = (i == 0);
            ch.error     = 1'b0;
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic t_in_beat make_number(input logic [31:0] v, input logic [5:0] r,
                                             input logic [5:0] m);
        t_in_beat b;
        b.value      = v;
        b.radix      = r;
        b.min_digits = m;
        return b;
    endfunction

    function automatic t_in_beat random_number();
        t_in_beat b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b.value = $urandom;
            4, 5:       b.value = $urandom_range(0, 999);
            6:          b.value = '0;
            7:          b.value = 32'hFFFF_FFFF;
            default:    b.value = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 3) == 0) b.radix = 6'($urandom_range(0, 1));
            else b.radix = 6'($urandom_range(37, 63));
        end else begin
            b.radix = 6'($urandom_range(2, 36));
        end
        if ($urandom_range(0, 3) == 0) b.min_digits = 6'($urandom_range(0, 63));
        else b.min_digits = 6'($urandom_range(0, 10));
        return b;
    endfunction

    // one input beat; returns at the edge that accepts it
    task automatic send_number(input t_in_beat num);
        tx_data  <= num;
        tx_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        convert_number(num);
    endtask

    task automatic idle_gap(input int cycles);
        tx_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_all_chars();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("char error: %s", msg);
    endtask

    // receiver: random stall density that changes now and then, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready  <= 1'b0;
            hold_left <= 0;
            mode_left <= 0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= LONG_HOLD;
            rx_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(64, 256);
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 25;
                    default: stall_pct <= 65;
                endcase
            end else begin
                mode_left <= mode_left - 1;
            end
            rx_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_chars
        t_out_beat want;
        if (i_rst_n && o_valid && rx_ready) begin
            if (pending_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat char=%0h last=%b err=%b",
                                        o_data.char_code, o_data.last, o_data.error));
            end else begin
                want = pending_chars.pop_front();
                if (o_data.char_code !== want.char_code || o_data.last !== want.last ||
                    o_data.error !== want.error)
                    flag_mismatch($sformatf(
                        "want char=%0h last=%b err=%b, got char=%0h last=%b err=%b",
                        want.char_code, want.last, want.error,
                        o_data.char_code, o_data.last, o_data.error));
            end
        end
    end

    task automatic test_value_extremes();
        send_number(make_number(32'd0, 6'd10, 6'd0));
        send_number(make_number(32'hFFFF_FFFF, 6'd2, 6'd0));
        send_number(make_number(32'hFFFF_FFFF, 6'd36, 6'd1));
        send_number(make_number(32'hFFFF_FFFF, 6'd16, 6'd0));
        send_number(make_number(32'h8000_0000, 6'd2, 6'd0));
        idle_gap(3);
        send_number(make_number(32'd35, 6'd36, 6'd0));
        send_number(make_number(32'd10, 6'd11, 6'd0));
        send_number(make_number(32'd9, 6'd10, 6'd0));
        send_number(make_number(32'd1, 6'd3, 6'd0));
        send_number(make_number(32'd1295, 6'd36, 6'd2));
        wait_for_all_chars();
    endtask

    // zero fill, a minimum of 1 with no fill, minimum above the store saturated
    task automatic test_padding();
        send_number(make_number(32'd0, 6'd2, 6'd32));
        send_number(make_number(32'd255, 6'd16, 6'd8));
        send_number(make_number(32'd5, 6'd10, 6'd33));
        send_number(make_number(32'd0, 6'd7, 6'd63));
        send_number(make_number(32'd123, 6'd10, 6'd1));
        wait_for_all_chars();
    endtask

    task automatic test_bad_radix();
        send_number(make_number(32'd77, 6'd0, 6'd5));
        send_number(make_number(32'hFFFF_FFFF, 6'd1, 6'd63));
        send_number(make_number(32'd0, 6'd37, 6'd0));
        send_number(make_number(32'h5A5A_A5A5, 6'd63, 6'd32));
        wait_for_all_chars();
    endtask

    // receiver holds off while numbers keep coming so the input side backs up
    task automatic test_back_pressure();
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 12; i++) begin
            send_number(make_number($urandom, 6'($urandom_range(16, 36)),
                                    6'($urandom_range(0, 4))));
        end
        wait_for_all_chars();
    endtask

    task automatic test_random_numbers(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_number(random_number());
                sent++;
            end
            if ($urandom_range(0, 4) != 0) idle_gap($urandom_range(1, 16));
        end
        wait_for_all_chars();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_value_extremes();
        test_padding();
        test_bad_radix();
        test_back_pressure();
        test_random_numbers(RANDOM_NUM);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("integer_to_radix_digits: match");
        else
            $display("integer_to_radix_digits: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/itrd_pkg.sv
rtl/itrd_front.sv
rtl/itrd_queue.sv
rtl/itrd_back.sv
rtl/integer_to_radix_digits.sv
dv/tb_top.sv
